// File: rtl/cassette_tape_waveform_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cassette tape waveform generator
// ----------------------------------------------------------------------------
`ifndef CASSETTE_TAPE_WAVEFORM_GENERATOR_ASSERT_SVH
`define CASSETTE_TAPE_WAVEFORM_GENERATOR_ASSERT_SVH

// same-cycle implication, held off during reset
`define CTWG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctwg: property violated");

// next-cycle implication, held off during reset
`define CTWG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctwg: property violated");

`endif

// File: rtl/ctwg_pkg.sv
// ----------------------------------------------------------------------------
// ctwg_pkg
// Types and constants shared by the cassette tape waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ctwg_pkg;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SUPPLY  = 2'd1,
        CMD_END     = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_LOW250   = 2'd0,
        MODE_LOW500   = 2'd1,
        MODE_FSK      = 2'd2,
        MODE_RESERVED = 2'd3
    } t_speed;

    localparam logic REG_SPEED_MODE = 1'b0;
    localparam logic REG_SILENCE    = 1'b1;

    localparam logic [15:0] SILENCE_RESET = 16'd11025;

    typedef struct packed {
        logic [15:0] lead_left;
        logic [15:0] trail_left;
        logic [7:0]  shift_byte;
        logic [7:0]  bit_select;
        logic        current_bit;
        logic        half_phase;
        logic [5:0]  half_pos;
        logic [3:0]  fsk_left;
        logic [14:0] frac_err;
        logic        data_ended;
        logic [7:0]  held_byte;
        logic        held_valid;
        logic        end_signalled;
    } t_play_state;

    localparam t_play_state PLAY_STATE_RESET = '{
        lead_left:  SILENCE_RESET,
        trail_left: SILENCE_RESET,
        default:    '0
    };

    typedef struct packed {
        logic level;
        logic stalled;
        logic need_byte;
        logic done_res;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/ctwg_step.sv
// ----------------------------------------------------------------------------
// ctwg_step
// Next-state and result logic for one request: silence, low-speed
// clock-pulse cells and high-speed FSK half-cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module ctwg_step (
    input  ctwg_pkg::t_play_state i_state,
    input  ctwg_pkg::t_cmd        i_cmd,
    input  logic [7:0]            i_data_byte,
    input  ctwg_pkg::t_speed      i_speed_mode,
    input  logic [15:0]           i_silence_len,
    output ctwg_pkg::t_play_state o_next,
    output ctwg_pkg::t_result     o_result
);
    import ctwg_pkg::*;

    localparam int          FSK_NUM      = 245;
    localparam int          FSK_DEN      = 22528;
    localparam logic [9:0]  CYC_ONE_HI   = 10'd378;
    localparam logic [9:0]  CYC_ZERO_HI  = 10'd771;
    localparam logic [9:0]  CYC_ONE_LO   = 10'd381;
    localparam logic [9:0]  CYC_ZERO_LO  = 10'd765;
    localparam int          FSK_MAX_Q    = (771 * FSK_NUM + FSK_DEN - 1) / FSK_DEN;
    localparam int          SCALED_W     = 18;
    localparam logic [5:0]  PULSE_LEN    = 6'd3;
    localparam logic [5:0]  HALF_SLOW    = 6'd44;
    localparam logic [5:0]  HALF_FAST    = 6'd22;
    localparam logic [7:0]  FIRST_BIT    = 8'h80;

    t_play_state         s;
    logic                produced;
    logic                lvl;
    logic                stalled;
    logic                done;
    logic [9:0]          fsk_cycles;
    logic [SCALED_W-1:0] scaled;
    logic [FSK_MAX_Q-1:0] q_ge;
    logic [3:0]          q;
    logic [14:0]         q_frac;
    logic [3:0]          q_samples;
    logic [5:0]          half_len;
    logic [5:0]          pos_inc;
    logic                sel_bit;
    logic                load_now;
    logic [7:0]          cur_byte;
    logic [7:0]          cur_mask;
    logic                cur_phase;

    // byte and half-cell as seen after a possible load on this tick
    always_comb begin
        load_now  = (i_state.bit_select == 8'd0) && i_state.held_valid;
        cur_byte  = load_now ? i_state.held_byte : i_state.shift_byte;
        cur_mask  = load_now ? FIRST_BIT : i_state.bit_select;
        cur_phase = load_now ? 1'b0 : i_state.half_phase;
    end

    // cycle count to samples; remainder carried in frac_err
    always_comb begin
        fsk_cycles = i_state.current_bit ? CYC_ONE_HI : CYC_ZERO_HI;
        if (cur_phase) begin
            fsk_cycles = sel_bit ? CYC_ONE_LO : CYC_ZERO_LO;
        end else begin
            fsk_cycles = sel_bit ? CYC_ONE_HI : CYC_ZERO_HI;
        end
        scaled = SCALED_W'(fsk_cycles) * SCALED_W'(FSK_NUM) + SCALED_W'(i_state.frac_err);
        for (int k = 0; k < FSK_MAX_Q; k++) begin
            q_ge[k] = (scaled >= SCALED_W'((k + 1) * FSK_DEN));
        end
        q         = 4'($countones(q_ge));
        q_frac    = 15'(scaled - SCALED_W'(q) * SCALED_W'(FSK_DEN));
        q_samples = (q == 4'd0) ? 4'd1 : q;
    end

    assign sel_bit = |(cur_byte & cur_mask);

    always_comb begin
        s        = i_state;
        produced = 1'b0;
        lvl      = 1'b0;
        stalled  = 1'b0;
        done     = 1'b0;
        half_len = (i_speed_mode == MODE_LOW250) ? HALF_SLOW : HALF_FAST;
        pos_inc  = 6'd0;

        unique case (i_cmd)
            CMD_SUPPLY: begin
                if (!s.held_valid && !s.end_signalled) begin
                    s.held_byte  = i_data_byte;
                    s.held_valid = 1'b1;
                end
            end
            CMD_END: begin
                s.end_signalled = 1'b1;
            end
            CMD_RESTART: begin
                s            = PLAY_STATE_RESET;
                s.lead_left  = i_silence_len;
                s.trail_left = i_silence_len;
            end
            CMD_TICK: begin
                if (s.lead_left != 16'd0) begin
                    s.lead_left = s.lead_left - 16'd1;
                    produced    = 1'b1;
                end else if (!s.data_ended && i_speed_mode != MODE_RESERVED) begin
                    if (s.bit_select == 8'd0) begin
                        if (s.held_valid) begin
                            s.current_bit = 1'b0;
                            s.half_phase  = 1'b0;
                            s.half_pos    = 6'd0;
                            s.fsk_left    = 4'd0;
                            s.shift_byte  = s.held_byte;
                            s.bit_select  = FIRST_BIT;
                            s.held_valid  = 1'b0;
                        end else if (s.end_signalled) begin
                            s.data_ended  = 1'b1;
                            s.shift_byte  = 8'd0;
                            s.current_bit = 1'b0;
                            s.half_phase  = 1'b0;
                            s.half_pos    = 6'd0;
                            s.fsk_left    = 4'd0;
                        end else begin
                            stalled  = 1'b1;
                            produced = 1'b1;
                        end
                    end
                    if (!produced && s.bit_select != 8'd0) begin
                        produced = 1'b1;
                        if (i_speed_mode == MODE_FSK) begin
                            if (s.fsk_left == 4'd0) begin
                                s.current_bit = sel_bit;
                                s.fsk_left    = q_samples;
                                s.frac_err    = q_frac;
                            end
                            lvl        = !s.half_phase;
                            s.fsk_left = s.fsk_left - 4'd1;
                            if (s.fsk_left == 4'd0) begin
                                if (!s.half_phase) begin
                                    s.half_phase = 1'b1;
                                end else begin
                                    s.half_phase = 1'b0;
                                    s.bit_select = s.bit_select >> 1;
                                end
                            end
                        end else begin
                            if (s.half_pos == 6'd0) begin
                                s.current_bit = sel_bit;
                            end
                            if (!s.half_phase) begin
                                lvl = (s.half_pos < PULSE_LEN);
                            end else begin
                                lvl = s.current_bit && (s.half_pos < PULSE_LEN);
                            end
                            pos_inc    = s.half_pos + 6'd1;
                            s.half_pos = pos_inc;
                            if (pos_inc >= half_len) begin
                                s.half_pos = 6'd0;
                                if (!s.half_phase) begin
                                    s.half_phase = 1'b1;
                                end else begin
                                    s.half_phase = 1'b0;
                                    s.bit_select = s.bit_select >> 1;
                                end
                            end
                        end
                    end
                end
                if (!produced) begin
                    if (s.trail_left != 16'd0) begin
                        s.trail_left = s.trail_left - 16'd1;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        endcase
    end

    assign o_next             = s;
    assign o_result.level     = lvl;
    assign o_result.stalled   = stalled;
    assign o_result.need_byte = !s.held_valid && !s.end_signalled;
    assign o_result.done_res  = done;

endmodule

`default_nettype wire

// File: rtl/cassette_tape_waveform_generator.sv
// ----------------------------------------------------------------------------
// cassette_tape_waveform_generator
// Clock-pulse cassette tape waveform generator, one level per sample tick.
//
// Input stream: tuser carries the command (tick, supply byte, end, restart),
// tdata the payload byte. Only a tick request yields a result; the others
// update the holding register or playback state and yield nothing.
// Output stream: tdata = {need_byte, level}, tuser = {done_res, stalled}.
// Config channel: index 0 speed mode, index 1 silence length (the latter is
// loaded into the silence counters at restart or reset).
// A tick's result is registered in the result register, or in the skid
// register while the output is held. Throughput: one request per cycle
// while tready is high; all work sits between the state registers and
// the result register. Reset: speed mode 0, silence length 11025, playback
// state at its reset value, output empty. A stalled receiver is absorbed
// by a one-entry skid stage; tready drops only while that stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module cassette_tape_waveform_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] level, [1] need_byte, [7:2] zero
    output logic [1:0]  m_axis_tuser,   // [0] stalled, [1] done_res
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ctwg_pkg::*;

    t_speed      r_speed_mode;
    logic [15:0] r_silence_len;
    t_play_state r_state;
    t_play_state n_state;
    t_result     n_result;
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;
    logic        in_accept;
    logic        res_valid;
    t_cmd        cmd;

    assign cmd           = t_cmd'(s_axis_tuser);
    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign res_valid     = in_accept && (cmd == CMD_TICK);
    assign o_cfg_ready   = 1'b1;

    ctwg_step u_step (
        .i_state       (r_state),
        .i_cmd         (cmd),
        .i_data_byte   (s_axis_tdata),
        .i_speed_mode  (r_speed_mode),
        .i_silence_len (r_silence_len),
        .o_next        (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_mode  <= MODE_LOW250;
            r_silence_len <= SILENCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SPEED_MODE: r_speed_mode  <= t_speed'(i_cfg_data[1:0]);
                REG_SILENCE:    r_silence_len <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PLAY_STATE_RESET;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (res_valid) begin
            r_skid <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.need_byte, r_out.level};
    assign m_axis_tuser  = {r_out.done_res, r_out.stalled};

endmodule

`default_nettype wire

// File: rtl/ctwg_checker.sv
// ----------------------------------------------------------------------------
// ctwg_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cassette_tape_waveform_generator_assert.svh"

module ctwg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);

    logic       out_stall;
    logic       out_done;
    logic       out_wait;
    logic [9:0] out_word;

    assign out_stall = m_axis_tvalid && m_axis_tuser[0];
    assign out_done  = m_axis_tvalid && m_axis_tuser[1];
    assign out_wait  = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    // a stall and end of playback never coincide
    `CTWG_ASSERT_IMP(a_stall_not_done, i_clk, i_rst_n, out_stall, !out_done)

    // stalled or done results carry a low level
    `CTWG_ASSERT_IMP(a_invalid_level_low, i_clk, i_rst_n, out_stall || out_done, !m_axis_tdata[0])

    // a stall means the holding register is empty and end not seen
    `CTWG_ASSERT_IMP(a_stall_needs_byte, i_clk, i_rst_n, out_stall, m_axis_tdata[1])

    // a result held back by the receiver stays put
    `CTWG_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait, m_axis_tvalid && $stable(out_word))

endmodule

bind cassette_tape_waveform_generator ctwg_checker u_ctwg_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cassette tape waveform generator. A directed
// table covers reset silence, stall, ignored supplies, end of data, the
// reserved mode, deferred silence writes and a mid-stream mode change.
// Random stages follow, each with its own speed mode and silence length.
// Each tick result is checked against its typed table value or a bench
// model of the playback state. Both stream sides idle at random unless calm.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ctwg_pkg::*;

    localparam int unsigned FSK_MUL       = 245;
    localparam int unsigned FSK_DIV       = 22528;
    localparam int unsigned PULSE_SAMPLES = 3;
    localparam int          SETTLE        = 3;

    typedef enum bit {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        reg_idx;
        t_cmd        cmd;
        logic [15:0] value;
        bit          typed;
        t_result     want;
    } t_plan_row;

    typedef struct {
        t_speed      mode;
        logic [15:0] silence;
        int          items;
        bit          restart;
        bit          calm;
    } t_stage;

    localparam t_result AT_GAP   = '{level: 1'b0, stalled: 1'b0, need_byte: 1'b1, done_res: 1'b0};
    localparam t_result AT_STALL = '{level: 1'b0, stalled: 1'b1, need_byte: 1'b1, done_res: 1'b0};
    localparam t_result AT_DONE  = '{level: 1'b0, stalled: 1'b0, need_byte: 1'b0, done_res: 1'b1};
    localparam t_result NO_WANT  = '0;

    t_plan_row plan [31] = '{
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b1, AT_GAP},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b1, AT_GAP},
        '{ROW_CFG, REG_SILENCE,    CMD_TICK,    16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b1, AT_GAP},
        '{ROW_REQ, REG_SPEED_MODE, CMD_RESTART, 16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b1, AT_STALL},
        '{ROW_REQ, REG_SPEED_MODE, CMD_SUPPLY,  16'h00FF, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_SUPPLY,  16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_SPEED_MODE, CMD_TICK,    16'(MODE_FSK), 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_END,     16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_SUPPLY,  16'h00A5, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_SPEED_MODE, CMD_TICK,    16'(MODE_RESERVED), 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b1, AT_DONE},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b1, AT_DONE},
        '{ROW_CFG, REG_SILENCE,    CMD_TICK,    16'hFFFF, 1'b0, NO_WANT},
        '{ROW_CFG, REG_SPEED_MODE, CMD_TICK,    16'(MODE_LOW500), 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_RESTART, 16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b1, AT_GAP},
        '{ROW_CFG, REG_SILENCE,    CMD_TICK,    16'h0002, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_RESTART, 16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_SUPPLY,  16'h005A, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_END,     16'h0000, 1'b0, NO_WANT},
        '{ROW_REQ, REG_SPEED_MODE, CMD_TICK,    16'h0000, 1'b0, NO_WANT}
    };

    t_stage stages [7] = '{
        '{MODE_FSK,      16'd0,     250, 1'b1, 1'b0},
        '{MODE_LOW500,   16'd3,     260, 1'b0, 1'b1},
        '{MODE_LOW250,   16'd1,     350, 1'b1, 1'b0},
        '{MODE_RESERVED, 16'd65535,  50, 1'b1, 1'b0},
        '{MODE_FSK,      16'd9,     250, 1'b1, 1'b0},
        '{MODE_LOW500,   16'd0,     150, 0,    1'b0},
        '{MODE_FSK,      16'd20,    200, 0,    1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    // model of the playback state
    t_speed      cur_mode;
    logic [15:0] cur_silence;
    logic [15:0] lead_left, trail_left;
    logic [7:0]  shift_reg, bit_mask, held;
    logic        cur_bit, half_hi, data_done, held_ok, end_seen;
    logic [5:0]  half_pos;
    logic [3:0]  fsk_left;
    logic [14:0] frac_err;
    logic        tape_done;

    t_result tone_q[$];
    int      mismatches = 0;
    bit      calm = 1'b0;

    cassette_tape_waveform_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tuser  (s_axis_tuser),   // [1:0] command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [0] level, [1] need_byte
        .m_axis_tuser  (m_axis_tuser),   // [0] stalled, [1] done_res
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void drop_byte();
        shift_reg = '0;
        bit_mask  = '0;
        cur_bit   = 1'b0;
        half_hi   = 1'b0;
        half_pos  = '0;
        fsk_left  = '0;
    endfunction

    function automatic void reload_playback();
        lead_left  = cur_silence;
        trail_left = cur_silence;
        frac_err   = '0;
        data_done  = 1'b0;
        drop_byte();
        held       = '0;
        held_ok    = 1'b0;
        end_seen   = 1'b0;
    endfunction

    function automatic void next_half_cell();
        if (!half_hi) begin
            half_hi = 1'b1;
        end else begin
            half_hi  = 1'b0;
            bit_mask = bit_mask >> 1;
        end
    endfunction

    function automatic t_result play_tick();
        t_result     r;
        bit          busy;
        int unsigned span, cyc, scaled, whole;
        r    = '0;
        busy = 1'b0;
        if (lead_left != 0) begin
            lead_left = lead_left - 1;
            busy = 1'b1;
        end else if (!data_done && cur_mode != MODE_RESERVED) begin
            if (bit_mask == 0) begin
                if (held_ok) begin
                    drop_byte();
                    shift_reg = held;
                    bit_mask  = 8'h80;
                    held_ok   = 1'b0;
                end else if (end_seen) begin
                    data_done = 1'b1;
                    drop_byte();
                end else begin
                    r.stalled = 1'b1;
                    busy = 1'b1;
                end
            end
            if (!busy && bit_mask != 0) begin
                busy = 1'b1;
                if (cur_mode == MODE_FSK) begin
                    if (fsk_left == 0) begin
                        cur_bit = |(shift_reg & bit_mask);
                        if (!half_hi) cyc = cur_bit ? 378 : 771;
                        else          cyc = cur_bit ? 381 : 765;
                        scaled   = cyc * FSK_MUL + frac_err;
                        whole    = scaled / FSK_DIV;
                        frac_err = 15'(scaled - whole * FSK_DIV);
                        fsk_left = (whole == 0) ? 4'd1 : 4'(whole);
                    end
                    r.level  = !half_hi;
                    fsk_left = fsk_left - 1;
                    if (fsk_left == 0) next_half_cell();
                end else begin
                    span = (cur_mode == MODE_LOW250) ? 44 : 22;
                    if (half_pos == 0) cur_bit = |(shift_reg & bit_mask);
                    r.level  = (half_pos < PULSE_SAMPLES) && (!half_hi || cur_bit);
                    half_pos = half_pos + 1;
                    if (half_pos >= span) begin
                        half_pos = '0;
                        next_half_cell();
                    end
                end
            end
        end
        if (!busy) begin
            if (trail_left != 0) trail_left = trail_left - 1;
            else                 r.done_res = 1'b1;
        end
        r.need_byte = !held_ok && !end_seen;
        return r;
    endfunction

    task automatic push_req(t_cmd c, logic [7:0] b, bit typed, t_result want);
        t_result got;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        case (c)
            CMD_TICK: begin
                got = play_tick();
                tape_done = got.done_res;
                tone_q.push_back(typed ? want : got);
            end
            CMD_SUPPLY: begin
                if (!held_ok && !end_seen) begin
                    held    = b;
                    held_ok = 1'b1;
                end
            end
            CMD_END:     end_seen = 1'b1;
            CMD_RESTART: reload_playback();
            default: ;
        endcase
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(logic idx, logic [15:0] v);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tone_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_SPEED_MODE) cur_mode = t_speed'(v[1:0]);
        else                       cur_silence = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);
    end

    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tone_q.size() == 0) begin
                $error("result with no request pending");
                mismatches++;
            end else begin
                want = tone_q.pop_front();
                if (m_axis_tdata[0] !== want.level) begin
                    $error("level: expected %0b, got %0b", want.level, m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.stalled) begin
                    $error("stalled: expected %0b, got %0b", want.stalled, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tdata[1] !== want.need_byte) begin
                    $error("need_byte: expected %0b, got %0b",
                           want.need_byte, m_axis_tdata[1]);
                    mismatches++;
                end
                if (m_axis_tuser[1] !== want.done_res) begin
                    $error("done_res: expected %0b, got %0b",
                           want.done_res, m_axis_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : run
        int   roll;
        t_cmd pick;
        cur_mode    = MODE_LOW250;
        cur_silence = SILENCE_RESET;
        tape_done   = 1'b0;
        reload_playback();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].reg_idx, plan[i].value);
            else
                push_req(plan[i].cmd, plan[i].value[7:0], plan[i].typed, plan[i].want);
        end

        foreach (stages[s]) begin
            write_reg(REG_SPEED_MODE, 16'(stages[s].mode));
            write_reg(REG_SILENCE, stages[s].silence);
            calm = stages[s].calm;
            if (stages[s].restart) push_req(CMD_RESTART, 8'h00, 1'b0, NO_WANT);
            repeat (stages[s].items) begin
                roll = $urandom_range(0, 999);
                // mostly ticks, bytes supplied when the holder is empty
                if (roll < 4 || (tape_done && roll < 150))
                    pick = CMD_RESTART;
                else if (roll < 12)
                    pick = CMD_END;
                else if (roll < 50 || (!held_ok && !end_seen && roll < 450))
                    pick = CMD_SUPPLY;
                else
                    pick = CMD_TICK;
                push_req(pick, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
            end
        end
        calm = 1'b0;

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tone_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/ctwg_pkg.sv
rtl/ctwg_step.sv
rtl/cassette_tape_waveform_generator.sv
rtl/ctwg_checker.sv
tb/tb_top.sv
